### hw/rtl/imu_frame_deframer_crc16_defines.svh
// Assertion macros for the IMU frame deframer.
// Used by imu_frame_deframer_crc16.sv; no other dependencies.
`ifndef IMU_FRAME_DEFRAMER_CRC16_DEFINES_SVH
`define IMU_FRAME_DEFRAMER_CRC16_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define IFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define IFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");
`else
`define IFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/imufd_pkg.sv
// Package for the IMU frame deframer: frame geometry, header codes,
// status codes and the CRC-16/CCITT byte update. No dependencies.
package imufd_pkg;

  localparam int unsigned FRAME_BYTES = 57;
  localparam int unsigned SUB_BYTES   = FRAME_BYTES / 3;
  localparam int unsigned CRC_SPAN    = 16;
  localparam int unsigned WORDS       = 9;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned SUB_W       = $clog2(SUB_BYTES);
  localparam int unsigned WIDX_W      = $clog2(WORDS);

  localparam logic [7:0]  HDR_SYNC0   = 8'h55;
  localparam logic [7:0]  HDR_SYNC1   = 8'hAA;
  localparam logic [7:0]  HDR_TYPE    = 8'h01;
  localparam logic [7:0]  SLAVE_ID_RST = 8'hD8;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_HDR_ERR = 2'd2
  } status_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/imu_frame_deframer_crc16.sv
// Results appear on the out_ port in the cycle after the completing byte. Throughput:
// one byte per cycle unless stalled; the byte path is one CRC-16 byte update and a
// register write, and the output register takes a new result while the last one drains.
// Reset: rst_n is synchronous, active low; it restarts framing, sets the running CRC to
// FFFF, the expected slave id to D8 and drops any pending result.
`include "imu_frame_deframer_crc16_defines.svh"

// Top level of the IMU frame deframer; uses imufd_pkg and the defines header.
module imu_frame_deframer_crc16
  import imufd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_expected_slave_id,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_accel_x,
  output logic [31:0] out_accel_y,
  output logic [31:0] out_accel_z,
  output logic [31:0] out_rate_x,
  output logic [31:0] out_rate_y,
  output logic [31:0] out_rate_z,
  output logic [31:0] out_roll_word,
  output logic [31:0] out_pitch_word,
  output logic [31:0] out_yaw_word
);

  // Framing state: position in the frame, subframe index and position in the subframe
  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic [1:0]        sub_r,    sub_nxt;
  logic [SUB_W-1:0]  subpos_r, subpos_nxt;
  logic [15:0]       crc_r,    crc_nxt;
  logic [7:0]        crc_low_r, crc_low_nxt;
  logic              fail_r,   fail_nxt;
  logic [7:0]        slave_id_r;

  // Captured header bytes and data words (written before every read in a frame)
  logic [7:0]        hdr_r [3];
  logic [31:0]       data_r [WORDS];

  // Result register
  logic              out_valid_r;
  status_t           status_r;
  logic [31:0]       word_r [WORDS];

  logic              in_acc;
  logic              wrap;
  logic [1:0]        sub_cur;
  logic [SUB_W-1:0]  subpos_cur;
  logic [POS_W-1:0]  pos_cur;
  logic [15:0]       crc_base;
  logic              hdr_bad;
  logic              last_byte;
  logic              in_data;
  logic [SUB_W-1:0]  data_off;
  logic [WIDX_W-1:0] widx;
  logic [1:0]        lane;
  logic              emit;
  status_t           status_nxt;

  assign cfg_ready = 1'b1;
  // Take a byte whenever the result register is free or draining this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  // Treat an out-of-range position as the start of a new frame
  assign wrap       = (pos_r >= POS_W'(FRAME_BYTES));
  assign pos_cur    = wrap ? '0 : pos_r;
  assign sub_cur    = wrap ? '0 : sub_r;
  assign subpos_cur = wrap ? '0 : subpos_r;

  // Header group check on the fourth byte of the frame
  assign hdr_bad = (pos_cur == POS_W'(3)) &&
                   ((hdr_r[0] != HDR_SYNC0) || (hdr_r[1] != HDR_SYNC1) ||
                    (hdr_r[2] != slave_id_r) || (in_rx_byte != HDR_TYPE));
  assign last_byte = (pos_cur == POS_W'(FRAME_BYTES - 1));
  assign emit      = hdr_bad || last_byte;

  // Data byte placement: twelve bytes after the subframe header, little-endian words
  assign in_data  = (subpos_cur >= SUB_W'(4)) && (subpos_cur < SUB_W'(CRC_SPAN));
  assign data_off = subpos_cur - SUB_W'(4);
  assign widx     = WIDX_W'({2'b00, sub_cur} * 4'd3) + WIDX_W'(data_off[3:2]);
  assign lane     = data_off[1:0];

  always_comb begin
    // Restart the CRC at each subframe start, fold in the covered bytes
    crc_base    = (subpos_cur == '0) ? CRC_INIT : crc_r;
    crc_nxt     = (subpos_cur < SUB_W'(CRC_SPAN)) ? crc_update(crc_base, in_rx_byte) : crc_base;
    crc_low_nxt = (subpos_cur == SUB_W'(CRC_SPAN)) ? in_rx_byte : crc_low_r;
    fail_nxt    = fail_r;
    if ((subpos_cur == SUB_W'(CRC_SPAN + 1)) && ({in_rx_byte, crc_low_r} != crc_r)) begin
      fail_nxt = 1'b1;
    end

    if (subpos_cur == SUB_W'(SUB_BYTES - 1)) begin
      subpos_nxt = '0;
      sub_nxt    = sub_cur + 2'd1;
    end else begin
      subpos_nxt = subpos_cur + SUB_W'(1);
      sub_nxt    = sub_cur;
    end
    pos_nxt = pos_cur + POS_W'(1);

    if (hdr_bad) begin
      status_nxt = ST_HDR_ERR;
    end else if (fail_nxt) begin
      status_nxt = ST_CRC_ERR;
    end else begin
      status_nxt = ST_OK;
    end

    // Drop back to the frame start after any result
    if (emit) begin
      pos_nxt     = '0;
      sub_nxt     = '0;
      subpos_nxt  = '0;
      crc_nxt     = CRC_INIT;
      crc_low_nxt = '0;
      fail_nxt    = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sub_r       <= '0;
      subpos_r    <= '0;
      crc_r       <= CRC_INIT;
      crc_low_r   <= '0;
      fail_r      <= 1'b0;
      slave_id_r  <= SLAVE_ID_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slave_id_r <= cfg_expected_slave_id;
      end
      if (in_acc) begin
        pos_r     <= pos_nxt;
        sub_r     <= sub_nxt;
        subpos_r  <= subpos_nxt;
        crc_r     <= crc_nxt;
        crc_low_r <= crc_low_nxt;
        fail_r    <= fail_nxt;
      end
      // Hold a pending result until out_ready takes it
      if (in_acc && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: captured bytes and the result words
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (pos_cur < POS_W'(3)) begin
        hdr_r[pos_cur[1:0]] <= in_rx_byte;
      end
      if (in_data && !hdr_bad) begin
        data_r[widx][{lane, 3'b000} +: 8] <= in_rx_byte;
      end
      if (emit) begin
        status_r <= status_nxt;
        for (int i = 0; i < WORDS; i++) begin
          word_r[i] <= (status_nxt == ST_OK) ? data_r[i] : 32'h0;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_accel_x    = word_r[0];
  assign out_accel_y    = word_r[1];
  assign out_accel_z    = word_r[2];
  assign out_rate_x     = word_r[3];
  assign out_rate_y     = word_r[4];
  assign out_rate_z     = word_r[5];
  assign out_roll_word  = word_r[6];
  assign out_pitch_word = word_r[7];
  assign out_yaw_word   = word_r[8];

  // The frame counter never leaves the frame
  `IFD_ASSERT_IMPL(a_pos_range, clk, rst_n, 1'b1, pos_r < POS_W'(FRAME_BYTES))
  // The subframe position and subframe index stay in range
  `IFD_ASSERT_IMPL(a_sub_range, clk, rst_n, 1'b1, subpos_r < SUB_W'(SUB_BYTES) && sub_r != 2'd3)
  // The closing byte of a frame always yields a pending result
  `IFD_ASSERT_NEXT(a_last_emits, clk, rst_n, in_valid && in_ready && pos_r == POS_W'(FRAME_BYTES - 1), out_valid)
  // Error results carry zero data in the checked words, accel_x and yaw_word
  `IFD_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK, out_accel_x == 32'h0 && out_yaw_word == 32'h0)

endmodule
